FILE: src/first_fit_block_allocator_defines.svh
// Assertion macros shared by the allocator RTL.
// Expects clk and rst to be visible in the module that uses them.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define FFBA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define FFBA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/ffba_pkg.sv
// Shared types and constants of the first-fit block allocator.
// No dependencies; imported by the allocator top and the engine.
package ffba_pkg;

  localparam int MAX_BLOCKS   = 64;
  localparam int HEADER_BYTES = 24;
  localparam int IDX_W        = $clog2(MAX_BLOCKS);
  localparam int CNT_W        = $clog2(MAX_BLOCKS + 1);
  localparam int CFG_IDX_W    = 2;

  // Request codes.
  localparam logic [1:0] REQ_ALLOC  = 2'd0;
  localparam logic [1:0] REQ_FREE   = 2'd1;
  localparam logic [1:0] REQ_RESIZE = 2'd2;
  localparam logic [1:0] REQ_CALLOC = 2'd3;

  // Status codes.
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_ZERO    = 3'd1;
  localparam logic [2:0] ST_NOSPACE = 3'd2;
  localparam logic [2:0] ST_DOUBLE  = 3'd3;
  localparam logic [2:0] ST_BADADDR = 3'd4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_HEAP_START = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_HEAP_END   = CFG_IDX_W'(1);

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] size_bytes;
    logic [31:0] item_count;
    logic [31:0] payload_address;
  } ffba_in_t;

  typedef struct packed {
    logic [31:0] result_address;
    logic [2:0]  status;
    logic [31:0] copy_from;
    logic [31:0] copy_bytes;
  } ffba_out_t;

  // One block table entry as stored in the table memory.
  typedef struct packed {
    logic [31:0] start;
    logic [31:0] size;
    logic        free;
  } ffba_entry_t;

  // Configuration seen by the engine.
  typedef struct packed {
    logic        start_we;
    logic [31:0] start_value;
    logic [31:0] heap_end;
  } ffba_cfg_t;

endpackage

FILE: src/first_fit_block_allocator.sv
// First-fit block allocator: one request beat in, one result beat out per request.
// The block table lives in one synchronous memory that is read one entry per
// cycle, so the time a request takes grows with the entries it walks. A
// zero-size allocate, a zero-size resize of null and a free of null skip the
// walk and go straight from the accepting state to the result. A table walk
// stops at the first matching entry, or after it has walked all entries. A
// resize that must move its block walks twice, once to find the old block and
// once to place the new one, and then frees the old block in a state of its
// own. A zeroed allocate first passes through a multiply state and an
// overflow-check state. The table needs no clearing pass after reset, since
// only entries below the block count are read. The finished result sits in an
// output register, so a new request is taken while it waits; a second result
// waits in the engine, with the input stalled, until that register frees.
// Configuration writes are always ready.
module first_fit_block_allocator
  import ffba_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  ffba_in_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output ffba_out_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  logic        heap_end;
  logic [31:0] heap_end_reg;
  ffba_cfg_t   cfg;
  logic        res_valid;
  logic        res_ready;
  ffba_out_t   res;
  logic        ram_re;
  logic [IDX_W-1:0] ram_raddr;
  ffba_entry_t ram_rdata;
  logic        ram_we;
  logic [IDX_W-1:0] ram_waddr;
  ffba_entry_t ram_wdata;

  assign cfg_ready = 1'b1;
  assign heap_end  = cfg_valid && (cfg_index == REG_HEAP_END);

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_end_reg <= 32'hFFFF_FFFF;
    end else if (heap_end) begin
      heap_end_reg <= cfg_data;
    end
  end

  assign cfg.start_we    = cfg_valid && (cfg_index == REG_HEAP_START);
  assign cfg.start_value = cfg_data;
  assign cfg.heap_end    = heap_end_reg;

  // Output register: loads whenever it is empty or its beat is being taken.
  assign res_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data <= res;
    end
  end

  ffba_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata)
  );

  ffba_ram #(
    .DATA_W ($bits(ffba_entry_t)),
    .ADDR_W (IDX_W)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

FILE: src/ffba_ram.sv
// Generic simple dual-port RAM with registered read.
// Standalone; used for the allocator's block table.
module ffba_ram #(
  parameter int DATA_W = 65,
  parameter int ADDR_W = 6
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  localparam int DEPTH = 1 << ADDR_W;

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/ffba_engine.sv
// Request sequencer of the allocator: table walks, block reuse, append and free.
// Depends on ffba_pkg and the assertion macros; drives the table memory ports.
`include "first_fit_block_allocator_defines.svh"

module ffba_engine
  import ffba_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  ffba_cfg_t         cfg,
  input  logic              in_valid,
  output logic              in_stall,
  input  ffba_in_t          in_data,
  output logic              res_valid,
  input  logic              res_ready,
  output ffba_out_t         res,
  output logic              ram_re,
  output logic [IDX_W-1:0]  ram_raddr,
  input  ffba_entry_t       ram_rdata,
  output logic              ram_we,
  output logic [IDX_W-1:0]  ram_waddr,
  output ffba_entry_t       ram_wdata
);

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_MUL      = 6'b000010,
    S_CHK      = 6'b000100,
    S_SCAN     = 6'b001000,
    S_FREE_OLD = 6'b010000,
    S_DONE     = 6'b100000
  } state_t;

  state_t            state;
  ffba_in_t          req;
  logic [31:0]       alloc_size;
  logic [63:0]       prod;
  logic              scan_fit;   // 1: first-fit search, 0: address lookup
  logic              moving;     // resize that must move its block
  logic [CNT_W-1:0]  scan_idx;
  logic              rd_pend;
  logic [IDX_W-1:0]  rd_idx;
  logic [IDX_W-1:0]  old_idx;
  ffba_entry_t       old;
  logic [CNT_W-1:0]  count;
  logic [31:0]       brk;

  logic              fit_match;
  logic              addr_match;
  logic              hit;
  logic              scan_end;
  logic              issue;
  logic [33:0]       new_break;
  logic              append_ok;
  logic              alloc_fin;
  logic              alloc_ok;
  logic [31:0]       alloc_base;
  logic [31:0]       alloc_addr;

  assign in_stall  = (state != S_IDLE);
  assign res_valid = (state == S_DONE);

  always_comb begin
    fit_match  = ram_rdata.free && (ram_rdata.size >= alloc_size);
    addr_match = ({1'b0, ram_rdata.start} + 33'(HEADER_BYTES)) == {1'b0, req.payload_address};
    hit        = (state == S_SCAN) && rd_pend && (scan_fit ? fit_match : addr_match);
    scan_end   = (state == S_SCAN) && !rd_pend && (scan_idx >= count);
    issue      = (state == S_SCAN) && !hit && (scan_idx < count);
    new_break  = {2'b00, brk} + 34'(HEADER_BYTES) + {2'b00, alloc_size};
    append_ok  = (count < CNT_W'(MAX_BLOCKS)) && (new_break <= {2'b00, cfg.heap_end});
    alloc_fin  = scan_fit && (hit || scan_end);
    alloc_ok   = hit || append_ok;
    alloc_base = hit ? ram_rdata.start : brk;
    alloc_addr = alloc_base + 32'(HEADER_BYTES);
  end

  assign ram_re    = issue;
  assign ram_raddr = scan_idx[IDX_W-1:0];

  // The table memory has a single write port; a moving resize frees the old
  // block in a cycle of its own after the new block is claimed.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = rd_idx;
    ram_wdata = ram_rdata;
    if (state == S_SCAN) begin
      if (hit && scan_fit) begin
        ram_we         = 1'b1;
        ram_wdata.free = 1'b0;
      end else if (hit && (req.req_type == REQ_FREE) && !ram_rdata.free) begin
        ram_we         = 1'b1;
        ram_wdata.free = 1'b1;
      end else if (scan_end && scan_fit && append_ok) begin
        ram_we          = 1'b1;
        ram_waddr       = count[IDX_W-1:0];
        ram_wdata.start = brk;
        ram_wdata.size  = alloc_size;
        ram_wdata.free  = 1'b0;
      end
    end else if (state == S_FREE_OLD) begin
      ram_we         = 1'b1;
      ram_waddr      = old_idx;
      ram_wdata      = old;
      ram_wdata.free = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      count   <= '0;
      brk     <= '0;
      rd_pend <= 1'b0;
      moving  <= 1'b0;
    end else begin
      if (cfg.start_we && (count == '0)) begin
        brk <= cfg.start_value;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            req        <= in_data;
            alloc_size <= in_data.size_bytes;
            scan_idx   <= '0;
            rd_pend    <= 1'b0;
            moving     <= 1'b0;
            res        <= '0;
            unique case (in_data.req_type)
              REQ_ALLOC: begin
                if (in_data.size_bytes == '0) begin
                  res.status <= ST_ZERO;
                  state      <= S_DONE;
                end else begin
                  scan_fit <= 1'b1;
                  state    <= S_SCAN;
                end
              end
              REQ_FREE: begin
                if (in_data.payload_address == '0) begin
                  state <= S_DONE;
                end else begin
                  scan_fit <= 1'b0;
                  state    <= S_SCAN;
                end
              end
              REQ_RESIZE: begin
                if (in_data.payload_address != '0) begin
                  scan_fit <= 1'b0;
                  state    <= S_SCAN;
                end else if (in_data.size_bytes == '0) begin
                  res.status <= ST_ZERO;
                  state      <= S_DONE;
                end else begin
                  scan_fit <= 1'b1;
                  state    <= S_SCAN;
                end
              end
              REQ_CALLOC: begin
                state <= S_MUL;
              end
            endcase
          end
        end
        S_MUL: begin
          prod  <= {32'b0, req.item_count} * {32'b0, req.size_bytes};
          state <= S_CHK;
        end
        S_CHK: begin
          if (prod[63:32] != '0) begin
            res.status <= ST_BADADDR;
            state      <= S_DONE;
          end else if (prod[31:0] == '0) begin
            res.status <= ST_ZERO;
            state      <= S_DONE;
          end else begin
            alloc_size <= prod[31:0];
            scan_fit   <= 1'b1;
            state      <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (alloc_fin) begin
            rd_pend <= 1'b0;
            if (alloc_ok && !hit) begin
              count <= count + CNT_W'(1);
              brk   <= new_break[31:0];
            end
            res.result_address <= alloc_ok ? alloc_addr : '0;
            res.status         <= alloc_ok ? ST_OK : ST_NOSPACE;
            if (alloc_ok && (req.req_type == REQ_CALLOC)) begin
              res.copy_bytes <= alloc_size;
            end
            if (alloc_ok && moving) begin
              res.copy_from  <= req.payload_address;
              res.copy_bytes <= old.size;
              state          <= S_FREE_OLD;
            end else begin
              state <= S_DONE;
            end
          end else if (hit) begin
            rd_pend <= 1'b0;
            if (req.req_type == REQ_FREE) begin
              res.status <= ram_rdata.free ? ST_DOUBLE : ST_OK;
              state      <= S_DONE;
            end else if (ram_rdata.free) begin
              res.status <= ST_DOUBLE;
              state      <= S_DONE;
            end else if (ram_rdata.size >= req.size_bytes) begin
              res.result_address <= req.payload_address;
              state              <= S_DONE;
            end else begin
              // Block too small: remember it and restart as a first-fit search.
              old      <= ram_rdata;
              old_idx  <= rd_idx;
              moving   <= 1'b1;
              scan_fit <= 1'b1;
              scan_idx <= '0;
            end
          end else if (scan_end) begin
            res.status <= ST_BADADDR;
            state      <= S_DONE;
          end else begin
            rd_pend <= issue;
            if (issue) begin
              rd_idx   <= scan_idx[IDX_W-1:0];
              scan_idx <= scan_idx + CNT_W'(1);
            end
          end
        end
        S_FREE_OLD: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `FFBA_ASSERT_IMP(a_count_bound, 1'b1, count <= CNT_W'(MAX_BLOCKS), "block count exceeds table")
  `FFBA_ASSERT_IMP(a_write_state, ram_we, (state == S_SCAN) || (state == S_FREE_OLD), "table write outside a walk")
  `FFBA_ASSERT_NXT(a_append_count, scan_end && scan_fit && append_ok, count == CNT_W'($past(count) + CNT_W'(1)), "append did not grow the table")
  `FFBA_ASSERT_IMP(a_free_old_move, state == S_FREE_OLD, moving && (req.req_type == REQ_RESIZE), "old block freed without a moving resize")

endmodule
